FILE: hw/rtl/ept_pkg.sv
// ----------------------------------------------------------------------------
// ept_pkg: shared types and constants of the encoder position/velocity tracker
// Holds field widths, the channel count, result status codes and the command
// and status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package ept_pkg;

	localparam int MOTOR_COUNT = 6;
	localparam int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	localparam int MOTOR_W  = 3;
	localparam int COUNT_W  = 32;
	localparam int TIME_W   = 32;
	localparam int ANGLE_W  = 48;
	localparam int SPEED_W  = 32;
	localparam int STATUS_W = 2;

	// Q16 velocity: dividend is |2*diff| << Q_FRAC
	localparam int Q_FRAC    = 16;
	localparam int MAG_W     = COUNT_W + 1;
	localparam int DVD_W     = MAG_W + Q_FRAC;
	// quotient bits produced by the divider; larger quotients saturate early
	localparam int DIV_STEPS = COUNT_W + 1;
	localparam int ITER_W    = $clog2(DIV_STEPS);

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FIRST   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_DT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

	typedef struct packed {
		logic load;    // capture the incoming transaction
		logic read;    // read channel state, form deltas, update state
		logic prep;    // form magnitude, check overflow, seed the divider
		logic step;    // one restoring division step
		logic finish;  // form status and speed, drive the result
	} ept_cmd_t;

	typedef struct packed {
		logic in_range;  // incoming motor index names an existing channel
		logic skip_div;  // first reading, zero interval or certain overflow
	} ept_sts_t;

endpackage

FILE: hw/rtl/encoder_position_velocity_tracker.sv
// ----------------------------------------------------------------------------
// encoder_position_velocity_tracker: per-motor position and Q16 velocity
// Accumulates doubled encoder count deltas into a wrapping 48-bit position
// per channel and divides by the tick interval for a saturated velocity.
//
//   channel   handshake        fields
//   -------   --------------   -------------------------------------------
//   reading   start / busy     motor_index, encoder_count, time_stamp
//   result    done (strobe)    motor_echo, status, angle_total, speed
//
// A transaction is taken when start is high and busy is low.  A reading
// for a channel that does not exist is dropped with no result and busy
// stays low.  Any other reading passes through read, prepare, the 33
// steps of the one-bit restoring divider and finish, skipping the divider
// on a first reading, zero interval or certain overflow; done is registered
// after finish.  A new reading may be taken in the cycle done is high.
// done lasts one cycle and the receiver cannot stall it.  Reset clears all
// channels to unseen with zero position.
// ----------------------------------------------------------------------------
module encoder_position_velocity_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ept_pkg::MOTOR_W-1:0]         motor_index,
	input  logic signed [ept_pkg::COUNT_W-1:0]  encoder_count,
	input  logic [ept_pkg::TIME_W-1:0]          time_stamp,
	output logic                                done,
	output logic [ept_pkg::MOTOR_W-1:0]         motor_echo,
	output logic [ept_pkg::STATUS_W-1:0]        status,
	output logic signed [ept_pkg::ANGLE_W-1:0]  angle_total,
	output logic signed [ept_pkg::SPEED_W-1:0]  speed
);

	ept_pkg::ept_cmd_t cmd;
	ept_pkg::ept_sts_t sts;

	// sequencer: decides the path of each transaction
	ept_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: channel state, arithmetic and result registers
	ept_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.motor_index   (motor_index),
		.encoder_count (encoder_count),
		.time_stamp    (time_stamp),
		.done          (done),
		.motor_echo    (motor_echo),
		.status        (status),
		.angle_total   (angle_total),
		.speed         (speed)
	);

	// a result always lands when the sequencer has returned to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// out-of-range readings are dropped without occupying the block
	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (32'(motor_index) >= 32'(ept_pkg::MOTOR_COUNT))) |=> !busy)
		else $error("dropped reading left block busy");

	// first readings and zero intervals report no velocity
	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ((status == ept_pkg::ST_FIRST) || (status == ept_pkg::ST_ZERO_DT)))
		|-> (speed == '0))
		else $error("nonzero speed with first or zero-interval status");

	// result strobe is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

FILE: hw/rtl/ept_ctrl.sv
// ----------------------------------------------------------------------------
// ept_ctrl: sequencer of the tracker
// Walks each accepted reading through read and prepare, then divide unless
// the divider is skipped, then finish, and counts the division steps.
// ----------------------------------------------------------------------------
module ept_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ept_pkg::ept_sts_t   sts,
	output ept_pkg::ept_cmd_t   cmd,
	output logic                busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_PREP,
		S_DIV,
		S_FIN
	} state_t;

	state_t                     state_q;
	logic [ept_pkg::ITER_W-1:0] iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// drop out-of-range readings right here
					if (start && sts.in_range) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					iter_q <= '0;
					if (sts.skip_div) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (iter_q == ept_pkg::ITER_W'(ept_pkg::DIV_STEPS - 1)) begin
						state_q <= S_FIN;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.read   = (state_q == S_READ);
	assign cmd.prep   = (state_q == S_PREP);
	assign cmd.step   = (state_q == S_DIV);
	assign cmd.finish = (state_q == S_FIN);

endmodule

FILE: hw/rtl/ept_dp.sv
// ----------------------------------------------------------------------------
// ept_dp: datapath of the tracker
// Per-channel state, delta and position update, restoring divider and
// result registers.
// ----------------------------------------------------------------------------
module ept_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ept_pkg::ept_cmd_t                   cmd,
	output ept_pkg::ept_sts_t                   sts,
	input  logic [ept_pkg::MOTOR_W-1:0]         motor_index,
	input  logic signed [ept_pkg::COUNT_W-1:0]  encoder_count,
	input  logic [ept_pkg::TIME_W-1:0]          time_stamp,
	output logic                                done,
	output logic [ept_pkg::MOTOR_W-1:0]         motor_echo,
	output logic [ept_pkg::STATUS_W-1:0]        status,
	output logic signed [ept_pkg::ANGLE_W-1:0]  angle_total,
	output logic signed [ept_pkg::SPEED_W-1:0]  speed
);

	localparam int MC = ept_pkg::MOTOR_COUNT;

	// channel state
	logic                         seen_q       [MC];
	logic [ept_pkg::COUNT_W-1:0]  last_count_q [MC];
	logic [ept_pkg::TIME_W-1:0]   last_time_q  [MC];
	logic [ept_pkg::ANGLE_W-1:0]  angle_sum_q  [MC];

	// captured transaction
	logic [ept_pkg::IDX_W-1:0]    idx_q;
	logic [ept_pkg::MOTOR_W-1:0]  motor_q;
	logic [ept_pkg::COUNT_W-1:0]  cnt_q;
	logic [ept_pkg::TIME_W-1:0]   ts_q;

	// per-reading working registers
	logic                         first_q;
	logic [ept_pkg::COUNT_W-1:0]  diff_q;
	logic [ept_pkg::TIME_W-1:0]   dt_q;
	logic [ept_pkg::ANGLE_W-1:0]  angle_q;
	logic                         neg_q;
	logic                         dtz_q;
	logic                         ovf_q;
	logic [ept_pkg::TIME_W-1:0]   rem_q;
	logic [ept_pkg::DIV_STEPS-1:0] dvd_q;
	logic [ept_pkg::DIV_STEPS-1:0] quo_q;

	logic [31:0]                  mi_ext;
	logic [ept_pkg::IDX_W-1:0]    mi_idx;
	logic                         rd_seen;
	logic [ept_pkg::COUNT_W-1:0]  rd_diff;
	logic [ept_pkg::TIME_W-1:0]   rd_dt;
	logic [ept_pkg::ANGLE_W-1:0]  rd_delta;
	logic [ept_pkg::ANGLE_W-1:0]  rd_angle;
	logic [ept_pkg::MAG_W-1:0]    pr_delta;
	logic [ept_pkg::MAG_W-1:0]    pr_mag;
	logic [ept_pkg::DVD_W-1:0]    pr_dvd;
	logic                         pr_ovf;
	logic                         pr_dtz;
	logic [ept_pkg::TIME_W:0]     dv_trial;
	logic                         dv_ge;
	logic [ept_pkg::STATUS_W-1:0] fin_status;
	logic [ept_pkg::SPEED_W-1:0]  fin_speed;

	assign mi_ext       = 32'(motor_index);
	assign mi_idx       = mi_ext[ept_pkg::IDX_W-1:0];
	assign sts.in_range = (mi_ext < 32'(MC));

	// read stage: wrapping differences and new position
	assign rd_seen  = seen_q[idx_q];
	assign rd_diff  = cnt_q - last_count_q[idx_q];
	assign rd_dt    = ts_q - last_time_q[idx_q];
	assign rd_delta = {{(ept_pkg::ANGLE_W - ept_pkg::COUNT_W - 1){rd_diff[ept_pkg::COUNT_W-1]}},
		rd_diff, 1'b0};
	// an unseen channel has never moved, so its position is still zero
	assign rd_angle = rd_seen ? (angle_sum_q[idx_q] + rd_delta) : '0;

	// prepare stage: magnitude of 2*diff, overflow when quotient needs more bits
	assign pr_delta = {diff_q, 1'b0};
	assign pr_mag   = diff_q[ept_pkg::COUNT_W-1] ? (ept_pkg::MAG_W'(0) - pr_delta) : pr_delta;
	assign pr_dvd   = {pr_mag, {ept_pkg::Q_FRAC{1'b0}}};
	assign pr_ovf   = ({{ept_pkg::Q_FRAC{1'b0}}, pr_mag} >=
		{dt_q, {(ept_pkg::DIV_STEPS - ept_pkg::Q_FRAC){1'b0}}});
	assign pr_dtz   = (dt_q == '0);
	assign sts.skip_div = first_q || pr_dtz || pr_ovf;

	// one restoring step; remainder stays below dt so it fits TIME_W bits
	assign dv_trial = {rem_q, dvd_q[ept_pkg::DIV_STEPS-1]};
	assign dv_ge    = (dv_trial >= {1'b0, dt_q});

	always_comb begin
		fin_status = ept_pkg::ST_OK;
		fin_speed  = '0;
		if (first_q) begin
			fin_status = ept_pkg::ST_FIRST;
		end else if (dtz_q) begin
			fin_status = ept_pkg::ST_ZERO_DT;
		end else if (!neg_q) begin
			if (ovf_q || (quo_q > ept_pkg::DIV_STEPS'(33'h0_7FFF_FFFF))) begin
				fin_status = ept_pkg::ST_SAT;
				fin_speed  = 32'h7FFF_FFFF;
			end else begin
				fin_speed = quo_q[ept_pkg::SPEED_W-1:0];
			end
		end else begin
			if (ovf_q || (quo_q > ept_pkg::DIV_STEPS'(33'h0_8000_0000))) begin
				fin_status = ept_pkg::ST_SAT;
				fin_speed  = 32'h8000_0000;
			end else begin
				fin_speed = ept_pkg::SPEED_W'(0) - quo_q[ept_pkg::SPEED_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MC; i++) begin
				seen_q[i] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.read) begin
				seen_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q   <= mi_idx;
			motor_q <= motor_index;
			cnt_q   <= encoder_count;
			ts_q    <= time_stamp;
		end
		if (cmd.read) begin
			last_count_q[idx_q] <= cnt_q;
			last_time_q[idx_q]  <= ts_q;
			angle_sum_q[idx_q]  <= rd_angle;
			angle_q             <= rd_angle;
			first_q             <= !rd_seen;
			diff_q              <= rd_diff;
			dt_q                <= rd_dt;
		end
		if (cmd.prep) begin
			neg_q <= diff_q[ept_pkg::COUNT_W-1];
			dtz_q <= pr_dtz;
			ovf_q <= pr_ovf;
			rem_q <= ept_pkg::TIME_W'(pr_dvd[ept_pkg::DVD_W-1 -: ept_pkg::Q_FRAC]);
			dvd_q <= pr_dvd[ept_pkg::DIV_STEPS-1:0];
			quo_q <= '0;
		end
		if (cmd.step) begin
			rem_q <= dv_ge ? ept_pkg::TIME_W'(dv_trial - {1'b0, dt_q})
				: dv_trial[ept_pkg::TIME_W-1:0];
			dvd_q <= {dvd_q[ept_pkg::DIV_STEPS-2:0], 1'b0};
			quo_q <= {quo_q[ept_pkg::DIV_STEPS-2:0], dv_ge};
		end
		if (cmd.finish) begin
			motor_echo  <= motor_q;
			status      <= fin_status;
			angle_total <= angle_q;
			speed       <= fin_speed;
		end
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for encoder_position_velocity_tracker
// Feeds encoder readings through the start/busy command port and checks
// each result against an in-bench model of the per-channel position
// accumulator and the saturated Q16 velocity divider.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ept_pkg::*;

	// One encoder reading as presented on the command port
	typedef struct packed {
		logic [MOTOR_W-1:0] motor;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  stamp;
	} reading_t;

	// One result transaction as it should appear on the result port
	typedef struct packed {
		logic [MOTOR_W-1:0]         motor;
		logic [STATUS_W-1:0]        status;
		logic signed [ANGLE_W-1:0]  angle;
		logic signed [SPEED_W-1:0]  speed;
	} tracker_result_t;

	localparam int RANDOM_READINGS = 1500;
	localparam int DRAIN_CYCLES    = 60;    // comfortably above the slowest result path through the divider
	localparam int DRAIN_LIMIT     = 2000;

	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        start         = 1'b0;
	logic [MOTOR_W-1:0]          motor_index   = '0;
	logic signed [COUNT_W-1:0]   encoder_count = '0;
	logic [TIME_W-1:0]           time_stamp    = '0;
	logic                        busy;
	logic                        done;
	logic [MOTOR_W-1:0]          motor_echo;
	logic [STATUS_W-1:0]         status;
	logic signed [ANGLE_W-1:0]   angle_total;
	logic signed [SPEED_W-1:0]   speed;

	// Stimulus waiting to be driven and results waiting to be seen
	reading_t        reading_queue[$];
	tracker_result_t awaited_results[$];

	int total_readings;
	int taken_count;
	int mismatch_count;
	int burst_left;
	int gap_left;

	// Model state, one entry per motor channel
	bit                 chan_seen[MOTOR_COUNT];
	logic [COUNT_W-1:0] chan_count[MOTOR_COUNT];
	logic [TIME_W-1:0]  chan_stamp[MOTOR_COUNT];
	logic [ANGLE_W-1:0] chan_angle[MOTOR_COUNT];

	// Stimulus shaping only: the last count and stamp queued per channel
	logic [COUNT_W-1:0] gen_count[MOTOR_COUNT];
	logic [TIME_W-1:0]  gen_stamp[MOTOR_COUNT];

	encoder_position_velocity_tracker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.motor_index   (motor_index),
		.encoder_count (encoder_count),
		.time_stamp    (time_stamp),
		.done          (done),
		.motor_echo    (motor_echo),
		.status        (status),
		.angle_total   (angle_total),
		.speed         (speed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the channel model by one reading and produce the result it
	// should cause; readings for missing channels cause nothing.
	task automatic track_reading(input reading_t rd, output bit has_result,
			output tracker_result_t res);
		logic [COUNT_W-1:0]      diff;
		logic [TIME_W-1:0]       dt;
		logic signed [COUNT_W+1:0] twice;
		logic [COUNT_W+1:0]      mag;
		logic [ANGLE_W-1:0]      advance;
		logic [63:0]             quot;
		has_result = 1'b0;
		res        = '0;
		if (rd.motor >= MOTOR_COUNT)
			return;
		has_result = 1'b1;
		res.motor  = rd.motor;
		// First reading: store only, report the untouched position
		if (!chan_seen[rd.motor]) begin
			chan_seen[rd.motor]  = 1'b1;
			chan_count[rd.motor] = rd.count;
			chan_stamp[rd.motor] = rd.stamp;
			res.status = ST_FIRST;
			res.angle  = chan_angle[rd.motor];
			res.speed  = '0;
			return;
		end
		diff = rd.count - chan_count[rd.motor];
		dt   = rd.stamp - chan_stamp[rd.motor];
		chan_count[rd.motor] = rd.count;
		chan_stamp[rd.motor] = rd.stamp;
		// Doubled count difference, sign-extended to the position width
		twice   = $signed({diff[COUNT_W-1], diff, 1'b0});
		advance = {{(ANGLE_W-COUNT_W-1){diff[COUNT_W-1]}}, diff, 1'b0};
		chan_angle[rd.motor] = chan_angle[rd.motor] + advance;
		res.angle = chan_angle[rd.motor];
		if (dt == '0) begin
			res.status = ST_ZERO_DT;
			res.speed  = '0;
			return;
		end
		mag  = twice[COUNT_W+1] ? -twice : twice;
		quot = {14'd0, mag, 16'd0} / {32'd0, dt};
		res.status = ST_OK;
		if (!twice[COUNT_W+1]) begin
			if (quot > 64'h7FFF_FFFF) begin
				quot       = 64'h7FFF_FFFF;
				res.status = ST_SAT;
			end
			res.speed = quot[31:0];
		end else begin
			if (quot > 64'h8000_0000) begin
				quot       = 64'h8000_0000;
				res.status = ST_SAT;
			end
			res.speed = -quot[31:0];
		end
	endtask

	// Queue one reading and remember its count and stamp for shaping
	task automatic add_reading(input logic [MOTOR_W-1:0] m, input logic [COUNT_W-1:0] c,
			input logic [TIME_W-1:0] t);
		reading_t rd;
		rd.motor = m;
		rd.count = c;
		rd.stamp = t;
		reading_queue.push_back(rd);
		if (m < MOTOR_COUNT) begin
			gen_count[m] = c;
			gen_stamp[m] = t;
		end
	endtask

	// Driver: on each rising edge, log a transaction if one was taken, then
	// hold the current reading while busy, or load the next one / idle.
	always @(posedge clk) begin : driver
		reading_t        nxt;
		tracker_result_t res;
		bit              has_res;
		if (arst_n) begin
			if (start && !busy) begin
				nxt.motor = motor_index;
				nxt.count = encoder_count;
				nxt.stamp = time_stamp;
				track_reading(nxt, has_res, res);
				if (has_res)
					awaited_results.push_back(res);
				taken_count++;
			end
			// The port is free when nothing is offered or the offer was just taken
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (reading_queue.size() > 0) begin
					nxt = reading_queue.pop_front();
					motor_index   <= nxt.motor;
					encoder_count <= nxt.count;
					time_stamp    <= nxt.stamp;
					start         <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// Start a new burst; a third of them follow with no gap at all
						burst_left = $urandom_range(1, 20);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: results cannot be held off, so take each one on its strobe
	// and compare it with the oldest outstanding expectation.
	always @(posedge clk) begin : monitor
		tracker_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: motor_echo %0d status %0d", motor_echo, status);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (motor_echo !== want.motor) begin
					$error("motor_echo: expected %0d, got %0d", want.motor, motor_echo);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				if (angle_total !== want.angle) begin
					$error("angle_total: expected %0d, got %0d", want.angle, angle_total);
					mismatch_count++;
				end
				if (speed !== want.speed) begin
					$error("speed: expected %0d, got %0d", want.speed, speed);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		int                 valid_added;
		int                 spin;
		int unsigned        pick;
		logic [MOTOR_W-1:0] m;
		logic [COUNT_W-1:0] c;
		logic [TIME_W-1:0]  t;

		taken_count    = 0;
		mismatch_count = 0;
		burst_left     = $urandom_range(1, 20);
		gap_left       = 0;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			chan_seen[i]  = 1'b0;
			chan_angle[i] = '0;
			gen_count[i]  = '0;
			gen_stamp[i]  = '0;
		end

		// Missing channels before any state exists: drop silently
		add_reading(3'd6, 32'h1234_5678, 32'h0000_0010);
		add_reading(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Channel 0: first reading, a plain step, then a zero interval
		add_reading(3'd0, 32'h0000_0000, 32'h0000_0000);
		add_reading(3'd0, 32'h0000_0001, 32'h0000_0002);
		add_reading(3'd0, 32'hFFFF_FFFD, 32'h0000_0002);
		// Channel 1: largest unclamped positive speed, then clamp both ways
		add_reading(3'd1, 32'h0000_0000, 32'hFFFF_FFF0);
		add_reading(3'd1, 32'h7FFF_FFFF, 32'h0001_FFF0);
		add_reading(3'd1, 32'hFFFF_FFFF, 32'h0001_FFF1);
		add_reading(3'd1, 32'h7FFF_FFFE, 32'h0003_FFF0);
		// Channel 2: most negative speed that still fits, then a huge interval
		add_reading(3'd2, 32'h0000_0000, 32'd100);
		add_reading(3'd2, -32'sd16384, 32'd101);
		add_reading(3'd2, 32'h8000_0000, 32'd100);
		// Channel 3: tick counter wraps between the two readings
		add_reading(3'd3, 32'd1000, 32'hFFFF_FFF0);
		add_reading(3'd3, 32'd900, 32'h0000_0010);
		// Channel 4: count extremes
		add_reading(3'd4, 32'h8000_0000, 32'h0000_0000);
		add_reading(3'd4, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		// Channel 5: no motion, then no motion with a zero interval
		add_reading(3'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_reading(3'd5, 32'h7FFF_FFFF, 32'h8000_0000);
		add_reading(3'd5, 32'h7FFF_FFFF, 32'h8000_0000);
		// Missing channels once others hold state, then a large jump on channel 0
		add_reading(3'd6, 32'd5, 32'd5);
		add_reading(3'd7, 32'd0, 32'd0);
		add_reading(3'd0, 32'h4000_0000, 32'hFFFF_FFFF);

		// Random readings: mostly plausible motion with random content, some
		// wild jumps and extremes, and a little noise on missing channels.
		valid_added = 0;
		while (valid_added < RANDOM_READINGS) begin
			if ($urandom_range(0, 99) < 5) begin
				add_reading(MOTOR_W'($urandom_range(MOTOR_COUNT, 7)), $urandom, $urandom);
				continue;
			end
			m    = MOTOR_W'($urandom_range(0, MOTOR_COUNT - 1));
			pick = $urandom_range(0, 99);
			if (pick < 60)
				c = gen_count[m] + $urandom_range(0, 8192) - 32'd4096;
			else if (pick < 80)
				c = gen_count[m] + $urandom_range(0, 2097152) - 32'd1048576;
			else if (pick < 95)
				c = $urandom;
			else begin
				case ($urandom_range(0, 3))
					0: c = 32'h7FFF_FFFF;
					1: c = 32'h8000_0000;
					2: c = 32'h0000_0000;
					default: c = gen_count[m] ^ 32'h8000_0000;
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 60)
				t = gen_stamp[m] + $urandom_range(1, 5000);
			else if (pick < 70)
				t = gen_stamp[m];
			else if (pick < 85)
				t = gen_stamp[m] + $urandom_range(1, 16);
			else
				t = $urandom;
			add_reading(m, c, t);
			valid_added++;
		end
		total_readings = reading_queue.size();

		// Hold reset, then release it on a rising edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every transaction to be taken, then for the results to drain
		while (taken_count < total_readings)
			@(posedge clk);
		spin = 0;
		while (awaited_results.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		// Stay a while longer to catch any stray result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d expected results never arrived", awaited_results.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: ends the run as failed if it hangs past the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ept_pkg.sv
hw/rtl/ept_ctrl.sv
hw/rtl/ept_dp.sv
hw/rtl/encoder_position_velocity_tracker.sv
tb/tb.sv
